// File: rtl/bbl_pkg.sv
// Shared types and constants of the clamped line box filter.
`default_nettype none
package bbl_pkg;

	localparam int CH_W = 8;
	localparam int NUM_CH = 4;
	localparam int PIX_W = CH_W * NUM_CH;
	localparam int RADIUS_W = 4;
	localparam int RADIUS_TOP = (1 << RADIUS_W) - 1;
	localparam int WIN_IDX_W = $clog2(2 * RADIUS_TOP + 1);

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic fill;
		logic shift;
		logic [WIN_IDX_W-1:0] lo;
		logic [WIN_IDX_W-1:0] hi;
	} chain_cmd_t;

	typedef struct packed {
		logic run_last;
		logic line_done;
	} res_tag_t;

endpackage
`default_nettype wire

// File: rtl/box_blur_line_clamped_unit.sv
// Clamp-to-edge box filter over one image line: cell chain, sequencer, divide pipe.
//
// Usage:
//   Pixels enter on the in channel (valid/ready), four 8-bit channels each,
//   with line_end on the final pixel of a line. Results leave on the out
//   channel (valid/ready): the truncated mean of 2r+1 samples per channel,
//   run_last on the last result of an input pixel, line_done on the last
//   result of a line. The user writes the radius on the cfg channel only
//   while idle; the block does not enforce this. In a line, the result for
//   pixel j follows acceptance of pixel j+r and passes the two tree-level,
//   total and reciprocal product registers to the out register. One pixel
//   per cycle in steady state; the chain shifts once per pixel and the tree
//   takes one window per cycle while the receiver keeps up. At line end the
//   remaining r+1 results (n for a line of n <= r) drain one per cycle
//   while the receiver keeps up, plus up to r replication shifts for such
//   lines; input is held off meanwhile. Reset clears the radius to 1 and
//   empties the line and the pipe. A stalled receiver backs up through five
//   pipe registers and then holds off new pixels.
`default_nettype none
module box_blur_line_clamped_unit #(
	parameter int MAX_RADIUS = 15,
	parameter int MAX_LINE = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [bbl_pkg::RADIUS_W-1:0] radius,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [bbl_pkg::CH_W-1:0] red_in,
	input wire logic [bbl_pkg::CH_W-1:0] green_in,
	input wire logic [bbl_pkg::CH_W-1:0] blue_in,
	input wire logic [bbl_pkg::CH_W-1:0] alpha_in,
	input wire logic line_end,
	output logic out_valid,
	input wire logic out_ready,
	output logic [bbl_pkg::CH_W-1:0] red_out,
	output logic [bbl_pkg::CH_W-1:0] green_out,
	output logic [bbl_pkg::CH_W-1:0] blue_out,
	output logic [bbl_pkg::CH_W-1:0] alpha_out,
	output logic run_last,
	output logic line_done
);

	localparam int RM = (MAX_RADIUS < bbl_pkg::RADIUS_TOP) ? MAX_RADIUS : bbl_pkg::RADIUS_TOP;
	localparam int W = 2 * RM + 1;
	localparam int POS_W = $clog2(MAX_LINE);
	localparam int LW = $clog2(RM + 2);

	bbl_pkg::pix_t in_pix;
	bbl_pkg::pix_t head_src;
	bbl_pkg::pix_t cell_pix [W];
	bbl_pkg::pix_t taps [W];
	bbl_pkg::pix_t avg_pix;
	bbl_pkg::chain_cmd_t cmd;
	bbl_pkg::res_tag_t tag;
	bbl_pkg::res_tag_t out_tag;
	logic [bbl_pkg::RADIUS_W-1:0] r_eff;
	logic emit_valid;
	logic emit_ready;
	logic take_in;

	assign in_pix = {alpha_in, blue_in, green_in, red_in};
	assign head_src = take_in ? in_pix : cell_pix[0];

	bbl_ctrl #(
		.RM(RM),
		.MAX_LINE(MAX_LINE),
		.POS_W(POS_W),
		.LW(LW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.radius(radius),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.line_end(line_end),
		.emit_ready(emit_ready),
		.emit_valid(emit_valid),
		.tag(tag),
		.r_eff(r_eff),
		.cmd(cmd),
		.take_in(take_in)
	);

	for (genvar g = 0; g < W; g++) begin : g_cell
		bbl_pkg::pix_t prev;
		if (g == 0) begin : g_head
			assign prev = head_src;
		end else begin : g_body
			assign prev = cell_pix[g-1];
		end
		bbl_cell #(
			.IDX(g)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.fill_pix(in_pix),
			.prev_pix(prev),
			.pix(cell_pix[g]),
			.tap(taps[g])
		);
	end

	bbl_avg #(
		.W(W),
		.RM(RM)
	) u_avg (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(emit_valid),
		.in_ready(emit_ready),
		.taps(taps),
		.tag(tag),
		.r_eff(r_eff),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.avg_pix(avg_pix),
		.out_tag(out_tag)
	);

	assign red_out = avg_pix[0 * bbl_pkg::CH_W +: bbl_pkg::CH_W];
	assign green_out = avg_pix[1 * bbl_pkg::CH_W +: bbl_pkg::CH_W];
	assign blue_out = avg_pix[2 * bbl_pkg::CH_W +: bbl_pkg::CH_W];
	assign alpha_out = avg_pix[3 * bbl_pkg::CH_W +: bbl_pkg::CH_W];
	assign run_last = out_tag.run_last;
	assign line_done = out_tag.line_done;

endmodule
`default_nettype wire

// File: rtl/bbl_cell.sv
// One window cell: holds a pixel, shifts it on, and gates it into the window sum.
`default_nettype none
module bbl_cell #(
	parameter int IDX = 0
) (
	input wire logic clk,
	input wire bbl_pkg::chain_cmd_t cmd,
	input wire bbl_pkg::pix_t fill_pix,
	input wire bbl_pkg::pix_t prev_pix,
	output bbl_pkg::pix_t pix,
	output bbl_pkg::pix_t tap
);

	localparam logic [bbl_pkg::WIN_IDX_W-1:0] CELL_IDX = IDX[bbl_pkg::WIN_IDX_W-1:0];

	bbl_pkg::pix_t pix_q;
	logic in_win;

	always_ff @(posedge clk) begin
		if (cmd.fill) begin
			pix_q <= fill_pix;
		end else if (cmd.shift) begin
			pix_q <= prev_pix;
		end
	end

	assign in_win = (CELL_IDX >= cmd.lo) && (CELL_IDX <= cmd.hi);
	assign pix = pix_q;
	assign tap = in_win ? pix_q : '0;

endmodule
`default_nettype wire

// File: rtl/bbl_ctrl.sv
// Line sequencer: radius register, line position, pending results and flush.
`default_nettype none
module bbl_ctrl #(
	parameter int RM = 15,
	parameter int MAX_LINE = 4096,
	parameter int POS_W = 12,
	parameter int LW = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [bbl_pkg::RADIUS_W-1:0] radius,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic line_end,
	input wire logic emit_ready,
	output logic emit_valid,
	output bbl_pkg::res_tag_t tag,
	output logic [bbl_pkg::RADIUS_W-1:0] r_eff,
	output bbl_pkg::chain_cmd_t cmd,
	output logic take_in
);

	localparam int RW = bbl_pkg::RADIUS_W;
	localparam int IW = bbl_pkg::WIN_IDX_W;
	localparam int CW = ((LW > RW) ? LW : RW) + 1;

	logic [RW-1:0] radius_q;
	logic [POS_W-1:0] pos_q;
	logic [LW-1:0] lead_q;
	logic [LW-1:0] pend_q;
	logic busy_q;
	logic flush_q;

	logic [CW-1:0] lead_x;
	logic [CW-1:0] r_x;
	logic [CW-1:0] base;
	logic [CW:0] hi_x;
	logic due;
	logic last_due;
	logic pend_last;
	logic emit_fire;
	logic accept;
	logic is_end;

	assign r_eff = (radius_q > RW'(RM)) ? RW'(RM) : radius_q;
	assign lead_x = CW'(lead_q);
	assign r_x = CW'(r_eff);
	assign due = lead_x > r_x;
	assign last_due = lead_x == (r_x + CW'(1));
	assign base = lead_x - r_x - CW'(1);
	assign hi_x = (CW + 1)'(base) + ((CW + 1)'(r_x) << 1);
	assign pend_last = pend_q == LW'(1);

	assign emit_valid = due && (busy_q || flush_q);
	assign emit_fire = emit_valid && emit_ready;
	assign in_ready = !flush_q && (!busy_q || !due || (emit_fire && last_due));
	assign accept = in_valid && in_ready;
	assign is_end = line_end || (pos_q == POS_W'(MAX_LINE - 1));
	assign take_in = accept;
	assign cfg_ready = 1'b1;

	always_comb begin
		cmd.fill = accept && (pos_q == '0);
		cmd.shift = accept || (flush_q && (!due || emit_fire));
		cmd.lo = base[IW-1:0];
		cmd.hi = hi_x[IW-1:0];
		tag.run_last = flush_q ? pend_last : last_due;
		tag.line_done = flush_q && pend_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RW'(1);
			pos_q <= '0;
			lead_q <= '0;
			pend_q <= '0;
			busy_q <= 1'b0;
			flush_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radius_q <= radius;
			end
			if (accept) begin
				pos_q <= is_end ? '0 : pos_q + POS_W'(1);
			end
			busy_q <= accept ? !is_end : (busy_q && due);
			if (flush_q) begin
				if (emit_fire && pend_last) begin
					flush_q <= 1'b0;
					lead_q <= '0;
				end else if (!due) begin
					lead_q <= lead_q + LW'(1);
				end
				if (emit_fire) begin
					pend_q <= pend_q - LW'(1);
				end
			end else begin
				if (accept && !emit_fire) begin
					lead_q <= lead_q + LW'(1);
				end else if (!accept && emit_fire) begin
					lead_q <= lead_q - LW'(1);
				end
				if (accept && is_end) begin
					flush_q <= 1'b1;
					pend_q <= emit_fire ? lead_q : lead_q + LW'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/bbl_avg.sv
// Window sum tree and reciprocal divide, one result per cycle, with backpressure.
`default_nettype none
module bbl_avg #(
	parameter int W = 31,
	parameter int RM = 15
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire bbl_pkg::pix_t taps [W],
	input wire bbl_pkg::res_tag_t tag,
	input wire logic [bbl_pkg::RADIUS_W-1:0] r_eff,
	output logic out_valid,
	input wire logic out_ready,
	output bbl_pkg::pix_t avg_pix,
	output bbl_pkg::res_tag_t out_tag
);

	localparam int CH_W = bbl_pkg::CH_W;
	localparam int NCH = bbl_pkg::NUM_CH;
	localparam int SW = $clog2(W * ((1 << CH_W) - 1) + 1);
	localparam int G = (W + 3) / 4;
	localparam int G2 = (G + 3) / 4;
	localparam int DW = $clog2(2 * RM + 2);
	localparam int K = SW + DW;
	localparam int RCW = K + 1;
	localparam int PW = SW + RCW;
	localparam int RIW = $clog2(RM + 1);

	logic [RCW-1:0] recip [RM+1];
	logic [RCW-1:0] rcp_sel;

	logic [SW-1:0] grp1 [G][NCH];
	logic [SW-1:0] grp2 [G2][NCH];
	logic [SW-1:0] tot [NCH];

	logic [SW-1:0] grp_s1 [G][NCH];
	logic [SW-1:0] grp_s2 [G2][NCH];
	logic [SW-1:0] tot_s3 [NCH];
	logic [PW-1:0] prod_s4 [NCH];
	logic [CH_W-1:0] avg_q [NCH];
	bbl_pkg::res_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_q;
	logic v_s1, v_s2, v_s3, v_s4, v_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_o;

	for (genvar g = 0; g <= RM; g++) begin : g_recip
		localparam logic [RCW-1:0] RCP =
			RCW'(((64'd1 << K) + 64'(2 * g)) / 64'(2 * g + 1));
		assign recip[g] = RCP;
	end

	assign rcp_sel = recip[r_eff[RIW-1:0]];

	assign rdy_o = !v_q || out_ready;
	assign rdy4 = !v_s4 || rdy_o;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		for (int g = 0; g < G; g++) begin
			for (int c = 0; c < NCH; c++) begin
				grp1[g][c] = '0;
				for (int e = 0; e < 4; e++) begin
					if (4 * g + e < W) begin
						grp1[g][c] = grp1[g][c] + SW'(taps[4 * g + e][CH_W * c +: CH_W]);
					end
				end
			end
		end
	end

	always_comb begin
		for (int h = 0; h < G2; h++) begin
			for (int c = 0; c < NCH; c++) begin
				grp2[h][c] = '0;
				for (int e = 0; e < 4; e++) begin
					if (4 * h + e < G) begin
						grp2[h][c] = grp2[h][c] + grp_s1[4 * h + e][c];
					end
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			tot[c] = '0;
			for (int h = 0; h < G2; h++) begin
				tot[c] = tot[c] + grp_s2[h][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy_o) v_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			grp_s1 <= grp1;
			tag_s1 <= tag;
		end
		if (rdy2) begin
			grp_s2 <= grp2;
			tag_s2 <= tag_s1;
		end
		if (rdy3) begin
			tot_s3 <= tot;
			tag_s3 <= tag_s2;
		end
		if (rdy4) begin
			for (int c = 0; c < NCH; c++) begin
				prod_s4[c] <= PW'(tot_s3[c]) * PW'(rcp_sel);
			end
			tag_s4 <= tag_s3;
		end
		if (rdy_o) begin
			for (int c = 0; c < NCH; c++) begin
				avg_q[c] <= prod_s4[c][K +: CH_W];
			end
			tag_q <= tag_s4;
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			avg_pix[CH_W * c +: CH_W] = avg_q[c];
		end
	end

	assign out_valid = v_q;
	assign out_tag = tag_q;

endmodule
`default_nettype wire

// File: tb/box_blur_checker.sv
// Checker for the clamped line box filter: watches all channels, predicts results, compares.
`timescale 1ns / 1ps
module box_blur_checker #(
	parameter int MAX_RADIUS = 15,
	parameter int MAX_LINE = 4096
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [bbl_pkg::RADIUS_W-1:0] radius,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [bbl_pkg::CH_W-1:0] red_in,
	input wire logic [bbl_pkg::CH_W-1:0] green_in,
	input wire logic [bbl_pkg::CH_W-1:0] blue_in,
	input wire logic [bbl_pkg::CH_W-1:0] alpha_in,
	input wire logic line_end,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [bbl_pkg::CH_W-1:0] red_out,
	input wire logic [bbl_pkg::CH_W-1:0] green_out,
	input wire logic [bbl_pkg::CH_W-1:0] blue_out,
	input wire logic [bbl_pkg::CH_W-1:0] alpha_out,
	input wire logic run_last,
	input wire logic line_done,
	output int fail_count,
	output int pending
);

	localparam int CH_W = bbl_pkg::CH_W;
	localparam int NUM_CH = bbl_pkg::NUM_CH;
	localparam int RADIUS_W = bbl_pkg::RADIUS_W;
	localparam int RING_N = 2 * MAX_RADIUS + 1;
	localparam int BURST_MAX = 16;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
		logic run_last;
		logic line_done;
	} blur_res_t;

	bbl_pkg::pix_t ring [RING_N];
	bbl_pkg::pix_t head_pix;
	int unsigned line_pos;
	int unsigned given_cnt;
	logic [RADIUS_W-1:0] rad_q;
	blur_res_t blur_due_q[$];

	function automatic bbl_pkg::pix_t clamped_pix(int k, int tail);
		if (k < 0)
			return head_pix;
		if (k > tail)
			k = tail;
		return ring[k % RING_N];
	endfunction

	function automatic blur_res_t window_mean(int j, int r, int tail);
		int unsigned sum [NUM_CH];
		int k;
		int c;
		bbl_pkg::pix_t p;
		blur_res_t res;
		for (c = 0; c < NUM_CH; c++)
			sum[c] = 0;
		for (k = j - r; k <= j + r; k++) begin
			p = clamped_pix(k, tail);
			for (c = 0; c < NUM_CH; c++)
				sum[c] += p[c*CH_W +: CH_W];
		end
		res.red = CH_W'(sum[0] / (2 * r + 1));
		res.green = CH_W'(sum[1] / (2 * r + 1));
		res.blue = CH_W'(sum[2] / (2 * r + 1));
		res.alpha = CH_W'(sum[3] / (2 * r + 1));
		res.run_last = 1'b0;
		res.line_done = 1'b0;
		return res;
	endfunction

	task automatic absorb_pixel(input bbl_pkg::pix_t pix, input logic le);
		int unsigned i;
		int unsigned r;
		int unsigned upto;
		int unsigned n;
		int unsigned m;
		logic fin;
		logic any;
		blur_res_t res;
		i = line_pos;
		r = (rad_q > MAX_RADIUS) ? MAX_RADIUS : rad_q;
		fin = le || (i + 1 >= MAX_LINE);
		if (i == 0)
			head_pix = pix;
		ring[i % RING_N] = pix;
		any = 1'b0;
		upto = 0;
		if (fin) begin
			any = 1'b1;
			upto = i;
		end else if (i >= r) begin
			any = 1'b1;
			upto = i - r;
		end
		n = 0;
		if (any && given_cnt <= upto) begin
			n = upto - given_cnt + 1;
			if (n > BURST_MAX)
				n = BURST_MAX;
		end
		for (m = 0; m < n; m++) begin
			res = window_mean(given_cnt, r, i);
			if (m == n - 1) begin
				res.run_last = 1'b1;
				res.line_done = fin;
			end
			blur_due_q.push_back(res);
			given_cnt++;
		end
		if (fin) begin
			line_pos = 0;
			given_cnt = 0;
		end else begin
			line_pos = i + 1;
		end
	endtask

	task automatic note_mismatch(input blur_res_t want, input blur_res_t got, input logic none);
		fail_count++;
		if (fail_count <= 10) begin
			if (none) begin
				$write("%0t: unexpected result", $time);
			end else begin
				$write("%0t: expected rgba %02h %02h %02h %02h run_last %0b line_done %0b,",
					$time, want.red, want.green, want.blue, want.alpha, want.run_last,
					want.line_done);
				$write(" got");
			end
			$display(" rgba %02h %02h %02h %02h run_last %0b line_done %0b",
				got.red, got.green, got.blue, got.alpha, got.run_last, got.line_done);
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		blur_res_t got;
		blur_res_t want;
		if (!arst_n) begin
			line_pos = 0;
			given_cnt = 0;
			rad_q = RADIUS_W'(1);
			blur_due_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				rad_q = radius;
			if (in_valid && in_ready)
				absorb_pixel({alpha_in, blue_in, green_in, red_in}, line_end);
			if (out_valid && out_ready) begin
				got = {red_out, green_out, blue_out, alpha_out, run_last, line_done};
				if (blur_due_q.size() == 0) begin
					note_mismatch(got, got, 1'b1);
				end else begin
					want = blur_due_q.pop_front();
					if (got != want)
						note_mismatch(want, got, 1'b0);
				end
			end
		end
		pending = blur_due_q.size();
	end

endmodule

// File: tb/tb.sv
// Top of the box filter testbench: clock, reset, pixel and radius stimulus, verdict.
`timescale 1ns / 1ps
module tb;

	localparam int CH_W = bbl_pkg::CH_W;
	localparam int RADIUS_W = bbl_pkg::RADIUS_W;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS = 320;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [RADIUS_W-1:0] radius;
	logic in_valid;
	logic in_ready;
	logic [CH_W-1:0] red_in;
	logic [CH_W-1:0] green_in;
	logic [CH_W-1:0] blue_in;
	logic [CH_W-1:0] alpha_in;
	logic line_end;
	logic out_valid;
	logic out_ready;
	logic [CH_W-1:0] red_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] blue_out;
	logic [CH_W-1:0] alpha_out;
	logic run_last;
	logic line_done;

	int fail_count;
	int pending;
	int stall_cnt;
	int cur_rad;
	int rand_cnt;
	bit fast_tx;
	bit fast_rx;
	bit rx_hold;

	box_blur_line_clamped_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.radius(radius),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.alpha_in(alpha_in),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.alpha_out(alpha_out),
		.run_last(run_last),
		.line_done(line_done)
	);

	box_blur_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.radius(radius),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red_in(red_in),
		.green_in(green_in),
		.blue_in(blue_in),
		.alpha_in(alpha_in),
		.line_end(line_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red_out(red_out),
		.green_out(green_out),
		.blue_out(blue_out),
		.alpha_out(alpha_out),
		.run_last(run_last),
		.line_done(line_done),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [CH_W-1:0] pick_chan();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	task automatic put_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
			input logic [CH_W-1:0] b, input logic [CH_W-1:0] a, input logic le);
		int gap;
		gap = fast_tx ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		alpha_in <= a;
		line_end <= le;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_line(input int len);
		int k;
		for (k = 0; k < len; k++)
			put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), k == len - 1);
	endtask

	// hold input until every expected result is out, then let the pipe go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_radius(input int v);
		settle();
		radius <= RADIUS_W'(v);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cur_rad = v;
	endtask

	initial begin
		int gap;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				rx_hold = 1'b0;
				gap = HOLD_CYCLES;
			end else begin
				gap = fast_rx ? 0 : $urandom_range(0, 14);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		int len;
		int n;
		int phase;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		radius <= '0;
		in_valid <= 1'b0;
		red_in <= '0;
		green_in <= '0;
		blue_in <= '0;
		alpha_in <= '0;
		line_end <= 1'b0;
		stall_cnt <= 0;
		fast_tx = 1'b0;
		fast_rx = 1'b0;
		rx_hold = 1'b0;
		cur_rad = 1;
		rand_cnt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radius: extremes in a three-pixel line, then a one-pixel line
		put_pixel('0, '0, '0, '0, 1'b0);
		put_pixel('1, '1, '1, '1, 1'b0);
		put_pixel(8'h12, 8'hA5, 8'h5A, 8'hFF, 1'b1);
		put_pixel('1, '0, '1, '0, 1'b1);

		// pass-through window
		set_radius(0);
		put_pixel(8'h80, 8'h01, 8'hFE, 8'h7F, 1'b0);
		put_pixel('1, '1, '0, '0, 1'b1);

		// widest window: line shorter than the radius, then a sixteen-result burst
		set_radius(15);
		put_pixel('1, '1, '1, '1, 1'b0);
		put_pixel('0, '0, '0, '0, 1'b1);
		for (n = 0; n < 15; n++)
			put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b0);
		set_radius(0);
		put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b1);

		// shrink the radius mid-line
		set_radius(3);
		for (n = 0; n < 5; n++)
			put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b0);
		set_radius(1);
		put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b0);
		put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b1);

		// grow the radius mid-line
		for (n = 0; n < 4; n++)
			put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b0);
		set_radius(4);
		put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b0);
		put_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(), 1'b1);

		// back-pressure: stall the receiver while pixels keep coming
		set_radius(2);
		fast_tx = 1'b1;
		rx_hold = 1'b1;
		send_line(48);
		fast_tx = 1'b0;
		settle();

		phase = 0;
		while (rand_cnt < RANDOM_ITEMS) begin
			if (phase == 0)
				set_radius(0);
			else if (phase == 1)
				set_radius(15);
			else
				set_radius($urandom_range(0, 15));
			fast_tx = ($urandom_range(0, 3) == 0);
			fast_rx = ($urandom_range(0, 3) == 0);
			for (n = 0; n < 3; n++) begin
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, 40);
				else
					len = $urandom_range(1, 2 * cur_rad + 3);
				send_line(len);
				rand_cnt += len;
			end
			phase++;
		end

		settle();
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/bbl_pkg.sv
rtl/bbl_cell.sv
rtl/bbl_ctrl.sv
rtl/bbl_avg.sv
rtl/box_blur_line_clamped_unit.sv
tb/box_blur_checker.sv
tb/tb.sv
